// ===== rtl/fprx_pkg.sv =====
// fprx_pkg: shared types, constants and the crc-16 byte update for the
// framed packet receiver. No dependencies.

package fprx_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int LEN_W       = 9;
	localparam int MAX_LEN     = MAX_PAYLOAD + 2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] START_RESET  = 8'h5A;
	localparam logic [7:0] UNFRAG_RESET = 8'h00;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNFRAG_CODE = 1'd1;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_CONTROL,
		PH_SEQ,
		PH_PAYLOAD,
		PH_CRC_LO,
		PH_CRC_HI
	} phase_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] unfragmented_code;
	} cfg_t;

	typedef struct packed {
		logic             is_end;
		logic [7:0]       payload_byte;
		logic [7:0]       control_value;
		logic [7:0]       sequence_number;
		logic [LEN_W-1:0] payload_length;
		logic             crc_good;
	} result_t;

	// reflected ccitt (0x8408), one byte per call
	function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
		logic [7:0] x;
		x = b ^ c[7:0];
		x = x ^ (x << 4);
		return {x, c[15:8]} ^ {12'd0, x[7:4]} ^ {5'd0, x, 3'd0};
	endfunction

endpackage

// ===== rtl/fprx_if.sv =====
// fprx_in_if and fprx_out_if: valid/ready channels for received bytes and
// for results. Depends on fprx_pkg.

interface fprx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fprx_out_if;
	logic                     valid;
	logic                     ready;
	logic                     is_end;
	logic [7:0]               payload_byte;
	logic [7:0]               control_value;
	logic [7:0]               sequence_number;
	logic [fprx_pkg::LEN_W-1:0] payload_length;
	logic                     crc_good;

	modport source (output valid, output is_end, output payload_byte,
		output control_value, output sequence_number, output payload_length,
		output crc_good, input ready);
	modport sink (input valid, input is_end, input payload_byte,
		input control_value, input sequence_number, input payload_length,
		input crc_good, output ready);
endinterface

// ===== rtl/fprx_cfg_regs.sv =====
// fprx_cfg_regs: start byte and unfragmented code registers behind a plain
// write port. Depends on fprx_pkg.

module fprx_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fprx_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_data,
	output fprx_pkg::cfg_t                 cfg
);
	import fprx_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte        <= START_RESET;
			cfg_q.unfragmented_code <= UNFRAG_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_START_BYTE:  cfg_q.start_byte        <= cfg_data;
				REG_UNFRAG_CODE: cfg_q.unfragmented_code <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/fprx_parser.sv =====
// fprx_parser: frame state machine, header holds and running crc. One byte
// per transfer, at most one result per byte. Depends on fprx_pkg.

module fprx_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        rx_byte,
	input  fprx_pkg::cfg_t    cfg,
	output logic              res_valid,
	output fprx_pkg::result_t res
);
	import fprx_pkg::*;

	phase_t           phase_q, phase_d;
	logic [15:0]      crc_q, crc_d;
	logic [7:0]       len_lo_q, len_lo_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       ctrl_q, ctrl_d;
	logic [7:0]       seq_q, seq_d;
	logic [LEN_W-1:0] target_q, target_d;
	logic [LEN_W-1:0] count_q, count_d;
	logic [7:0]       crc_lo_q, crc_lo_d;

	logic [15:0]      crc_upd;
	logic [15:0]      len_full;
	logic             hdr_two;
	logic [LEN_W-1:0] hdr_len;
	logic [LEN_W-1:0] tgt_calc;

	assign crc_upd  = crc_step((phase_q == PH_HUNT) ? CRC_INIT : crc_q, rx_byte);
	assign len_full = {rx_byte, len_lo_q};
	assign hdr_two  = (phase_q == PH_SEQ);
	assign hdr_len  = hdr_two ? LEN_W'(2) : LEN_W'(1);
	assign tgt_calc = len_q - hdr_len;

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		len_lo_d  = len_lo_q;
		len_d     = len_q;
		ctrl_d    = ctrl_q;
		seq_d     = seq_q;
		target_d  = target_q;
		count_d   = count_q;
		crc_lo_d  = crc_lo_q;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == cfg.start_byte) begin
					crc_d   = crc_upd;
					count_d = '0;
					phase_d = PH_LEN_LO;
				end
			end
			PH_LEN_LO: begin
				len_lo_d = rx_byte;
				crc_d    = crc_upd;
				phase_d  = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d   = len_full[LEN_W-1:0];
				crc_d   = crc_upd;
				phase_d = (len_full > 16'(MAX_LEN)) ? PH_HUNT : PH_CONTROL;
			end
			PH_CONTROL, PH_SEQ: begin
				crc_d = crc_upd;
				if (phase_q == PH_CONTROL) ctrl_d = rx_byte;
				else                       seq_d  = rx_byte;
				if (phase_q == PH_CONTROL && rx_byte != cfg.unfragmented_code) begin
					phase_d = PH_SEQ;
				end else begin
					if (phase_q == PH_CONTROL) seq_d = '0;
					// too short for the header: drop silently
					if (len_q < hdr_len) begin
						phase_d = PH_HUNT;
					end else begin
						target_d = tgt_calc;
						count_d  = '0;
						phase_d  = (tgt_calc == '0) ? PH_CRC_LO : PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				crc_d            = crc_upd;
				count_d          = count_q + LEN_W'(1);
				res_valid        = 1'b1;
				res.payload_byte = rx_byte;
				if (count_d >= target_q) phase_d = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				crc_lo_d = rx_byte;
				phase_d  = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				res_valid           = 1'b1;
				res.is_end          = 1'b1;
				res.control_value   = ctrl_q;
				res.sequence_number = seq_q;
				res.payload_length  = target_q;
				res.crc_good        = ({rx_byte, crc_lo_q} == crc_q);
				phase_d             = PH_HUNT;
			end
			default: phase_d = PH_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else if (take) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			crc_q    <= crc_d;
			len_lo_q <= len_lo_d;
			len_q    <= len_d;
			ctrl_q   <= ctrl_d;
			seq_q    <= seq_d;
			target_q <= target_d;
			count_q  <= count_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// ===== rtl/fprx_out_reg.sv =====
// fprx_out_reg: result register between the parser and the result channel;
// loads a new result while the old one is being taken. Depends on fprx_pkg.

module fprx_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  fprx_pkg::result_t load_data,
	output logic              space,
	fprx_out_if.source        res
);
	import fprx_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign space = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (space && load) begin
			data_q <= load_data;
		end
	end

	assign res.valid           = valid_q;
	assign res.is_end          = data_q.is_end;
	assign res.payload_byte    = data_q.payload_byte;
	assign res.control_value   = data_q.control_value;
	assign res.sequence_number = data_q.sequence_number;
	assign res.payload_length  = data_q.payload_length;
	assign res.crc_good        = data_q.crc_good;

endmodule

// ===== rtl/framed_packet_receiver_crc16_unit.sv =====
// Framed packet receiver with CRC-16 check. Takes one byte per transfer,
// every cycle while the result register has room, and a byte's result
// (one payload byte result or one frame end status) appears in the result
// register in the cycle after its transfer. The byte side is ready whenever
// the result register is empty or its content is taken in the same cycle.
// The running CRC is the reflected CCITT form (0x8408, init FFFF) over start
// byte, header and payload; frames with a length above MAX_PAYLOAD+2, or too
// short for their header, are dropped without any result. Depends on
// fprx_pkg, fprx_if and the fprx submodules.

module framed_packet_receiver_crc16_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	fprx_in_if.sink                        rx,
	fprx_out_if.source                     res,
	input  logic                           cfg_we,
	input  logic [fprx_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [7:0]                     cfg_data
);
	import fprx_pkg::*;

	cfg_t    cfg;
	logic    space;
	logic    take;
	logic    p_valid;
	result_t p_res;

	assign rx.ready = space;
	assign take     = rx.valid && space;

	fprx_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	fprx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.rx_byte   (rx.rx_byte),
		.cfg       (cfg),
		.res_valid (p_valid),
		.res       (p_res)
	);

	fprx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && p_valid),
		.load_data (p_res),
		.space     (space),
		.res       (res)
	);

endmodule
